// File: src/tcw_pkg.sv
// Package for the text console writer: command and character codes, stream
// widths, the item kind decode and the controller/datapath interface structs.
// No dependencies.
package tcw_pkg;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // Input field widths
    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int CADDR_W = 11;

    // Output field widths
    localparam int OROW_W  = 5;
    localparam int OCOL_W  = 7;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FG    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BG    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // Character codes with special meaning
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Attribute after reset and clear: light grey on black
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // What the latched item asks for
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_NL    = 3'd1,
        K_CR    = 3'd2,
        K_EMIT  = 3'd3,
        K_CLEAR = 3'd4,
        K_FG    = 3'd5,
        K_BG    = 3'd6,
        K_READ  = 3'd7
    } kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;          // latch the incoming transaction
        logic first_emit;    // emit count comes from the item, not the counter
        logic emit;          // write one character at the cursor
        logic line_down;     // move down one row, column to zero
        logic scroll_begin;  // column to zero, start the sweep counter
        logic col_zero;      // carriage return
        logic set_fg;
        logic set_bg;
        logic clear_begin;   // cursor home, attribute reset, start sweep
        logic read_issue;    // read the addressed cell
        logic copy_step;     // one step of the scroll copy
        logic blank_step;    // write one blank cell at the sweep counter
        logic load_out;      // capture the result word
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        kind_t kind;
        logic  last_row;     // cursor sits on the bottom row
        logic  wrap_last;    // row full on the bottom row: scroll before write
        logic  first_one;    // item needs exactly one character
        logic  left_one;     // one character left in the running tab
        logic  copy_end;     // scroll copy has reached the last row
        logic  fill_end;     // sweep counter at the last cell
    } stat_t;

endpackage

// File: src/tcw_ctrl.sv
// Controller for the text console writer: sequences put, scroll, clear and
// read, and owns the stream handshakes. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  tcw_pkg::stat_t stat,
    output tcw_pkg::ctl_t  ctl
);
    import tcw_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_EMIT     = 7'b0000100,
        ST_COPY     = 7'b0001000,
        ST_BLANK    = 7'b0010000,
        ST_CLEAR    = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ret_emit_reg, ret_emit_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        ret_emit_next = ret_emit_reg;
        ctl           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.take   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                ctl.first_emit = 1'b1;
                state_next     = ST_FINISH;
                case (stat.kind)
                    K_NL: begin
                        if (stat.last_row) begin
                            ctl.scroll_begin = 1'b1;
                            ret_emit_next    = 1'b0;
                            state_next       = ST_COPY;
                        end else begin
                            ctl.line_down = 1'b1;
                        end
                    end
                    K_CR:  ctl.col_zero = 1'b1;
                    K_EMIT: begin
                        if (stat.wrap_last) begin
                            ctl.scroll_begin = 1'b1;
                            ret_emit_next    = 1'b1;
                            state_next       = ST_COPY;
                        end else begin
                            ctl.emit = 1'b1;
                            if (!stat.first_one) begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                    K_CLEAR: begin
                        ctl.clear_begin = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    K_FG:   ctl.set_fg     = 1'b1;
                    K_BG:   ctl.set_bg     = 1'b1;
                    K_READ: ctl.read_issue = 1'b1;
                    default: ;
                endcase
            end
            ST_EMIT: begin
                if (stat.wrap_last) begin
                    ctl.scroll_begin = 1'b1;
                    ret_emit_next    = 1'b1;
                    state_next       = ST_COPY;
                end else begin
                    ctl.emit = 1'b1;
                    if (stat.left_one) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_COPY: begin
                ctl.copy_step = 1'b1;
                if (stat.copy_end) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                ctl.blank_step = 1'b1;
                if (stat.fill_end) begin
                    state_next = ret_emit_reg ? ST_EMIT : ST_FINISH;
                end
            end
            ST_CLEAR: begin
                ctl.blank_step = 1'b1;
                if (stat.fill_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hand over the result and take the next transaction at once
                if (out_free) begin
                    ctl.load_out = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid) begin
                        ctl.take   = 1'b1;
                        state_next = ST_DISPATCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result valid until the receiver takes it
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctl.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_emit_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_emit_reg <= ret_emit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: src/tcw_datapath.sv
// Datapath for the text console writer: cell store, cursor, attribute,
// tab and sweep counters, and the result register. Depends on tcw_pkg.
module tcw_datapath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
    input  tcw_pkg::ctl_t                 ctl,
    output tcw_pkg::stat_t                stat,
    output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_LAST  = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS + 1);
    localparam int PH_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int TCNT_W     = $clog2(TAB_STOP + 1);
    localparam int PAD_W      = M_DATA_W - OROW_W - OCOL_W - ATTR_W - CELL_W;

    // Latched transaction
    logic [CMD_W-1:0]   cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [CADDR_W-1:0] caddr_reg;

    // Cursor, attribute and counters
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [TCNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Cell store
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_reg;
    logic              we, re;
    logic [ADDR_W-1:0] wa, ra;
    logic [CELL_W-1:0] wd;

    logic [M_DATA_W-1:0] out_reg;

    // Emit helpers
    kind_t             kind;
    logic              wrap;
    logic [ROW_W-1:0]  row_w;
    logic [COL_W-1:0]  col_w;
    logic [PH_W-1:0]   phase_base;
    logic [TCNT_W-1:0] init_cnt, left_cur;
    logic [CHAR_W-1:0] emit_byte;
    logic [ADDR_W-1:0] emit_addr;
    logic [CELL_W-1:0] blank_word;
    logic              addr_ok;

    // Decode the latched item
    always_comb begin
        kind = K_NONE;
        unique case (cmd_reg)
            CMD_PUT: begin
                case (char_reg)
                    CHAR_NL: kind = K_NL;
                    CHAR_CR: kind = K_CR;
                    default: kind = K_EMIT;
                endcase
            end
            CMD_CLEAR: kind = K_CLEAR;
            CMD_FG:    kind = K_FG;
            CMD_BG:    kind = K_BG;
            CMD_READ:  kind = K_READ;
            default:   kind = K_NONE;
        endcase
    end

    assign wrap       = (col_reg == COL_W'(COLUMNS));
    assign row_w      = wrap ? row_reg + ROW_W'(1) : row_reg;
    assign col_w      = wrap ? '0 : col_reg;
    assign phase_base = wrap ? '0 : phase_reg;
    assign emit_byte  = (char_reg == CHAR_TAB) ? CHAR_SPACE : char_reg;
    assign init_cnt   = (char_reg == CHAR_TAB) ? TCNT_W'(TAB_STOP) - TCNT_W'(phase_reg)
                                               : TCNT_W'(1);
    assign left_cur   = ctl.first_emit ? init_cnt : left_reg;
    assign emit_addr  = ADDR_W'(row_w) * ADDR_W'(COLUMNS) + ADDR_W'(col_w);
    assign blank_word = {attr_reg, CHAR_SPACE};
    assign addr_ok    = (32'(caddr_reg) < 32'(CELL_COUNT));

    // Status to the controller
    always_comb begin
        stat.kind      = kind;
        stat.last_row  = (row_reg == ROW_W'(ROWS - 1));
        stat.wrap_last = wrap && (row_reg == ROW_W'(ROWS - 1));
        stat.first_one = (init_cnt == TCNT_W'(1));
        stat.left_one  = (left_reg == TCNT_W'(1));
        stat.copy_end  = (cnt_reg == CNT_W'(COPY_LAST));
        stat.fill_end  = (cnt_reg == CNT_W'(CELL_COUNT - 1));
    end

    // Cursor, attribute and counter updates
    always_comb begin
        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        attr_next  = attr_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        if (ctl.emit) begin
            row_next   = row_w;
            col_next   = col_w + COL_W'(1);
            phase_next = (phase_base == PH_W'(TAB_STOP - 1)) ? '0 : phase_base + PH_W'(1);
            left_next  = left_cur - TCNT_W'(1);
        end
        if (ctl.line_down) begin
            row_next   = row_reg + ROW_W'(1);
            col_next   = '0;
            phase_next = '0;
        end
        if (ctl.scroll_begin) begin
            col_next   = '0;
            phase_next = '0;
            left_next  = left_cur;
            cnt_next   = '0;
        end
        if (ctl.col_zero) begin
            col_next   = '0;
            phase_next = '0;
        end
        if (ctl.set_fg) begin
            attr_next = {attr_reg[7:4], color_reg};
        end
        if (ctl.set_bg) begin
            attr_next = {color_reg, attr_reg[3:0]};
        end
        if (ctl.clear_begin) begin
            row_next   = '0;
            col_next   = '0;
            phase_next = '0;
            attr_next  = RESET_ATTR;
            cnt_next   = '0;
        end
        // Stop on the last copy step so the blank sweep starts at the last row
        if (ctl.copy_step && !stat.copy_end) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (ctl.blank_step) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Store port selection
    always_comb begin
        we = 1'b0;
        wa = emit_addr;
        wd = {attr_reg, emit_byte};
        re = 1'b0;
        ra = ADDR_W'(caddr_reg);
        if (ctl.emit) begin
            we = 1'b1;
        end
        if (ctl.blank_step) begin
            we = 1'b1;
            wa = cnt_reg[ADDR_W-1:0];
            wd = blank_word;
        end
        if (ctl.copy_step) begin
            // Read one row ahead, write the word read on the previous step
            re = !stat.copy_end;
            ra = cnt_reg[ADDR_W-1:0] + ADDR_W'(COLUMNS);
            we = (cnt_reg != '0);
            wa = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
            wd = rd_reg;
        end
        if (ctl.read_issue) begin
            re = addr_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_reg <= mem[ra];
        end
    end

    // Latch the transaction and the result word
    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            cmd_reg   <= s_tdata[2:0];
            char_reg  <= s_tdata[10:3];
            color_reg <= s_tdata[14:11];
            caddr_reg <= s_tdata[25:15];
        end
        if (ctl.load_out) begin
            out_reg <= {{PAD_W{1'b0}},
                        (kind == K_READ && addr_ok) ? rd_reg : CELL_W'(0),
                        attr_reg,
                        OCOL_W'(col_reg),
                        OROW_W'(row_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            attr_reg  <= RESET_ATTR;
            left_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            attr_reg  <= attr_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign m_tdata = out_reg;

endmodule

// File: src/text_console_writer_top.sv
// Top level of the text console writer: joins the controller and the
// datapath. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage: one command per input transaction on the s_ stream, one result per
// command on the m_ stream, in order. s_tdata carries cmd, char_code,
// color_value and cell_address; m_tdata returns the cursor row and column,
// the attribute and, for a read, the cell word (zero otherwise).
// Carriage return, newline without scroll, color changes, reads, unused
// codes and a single character go from dispatch straight to result capture.
// A tab writes one cell per cycle, TAB_STOP - (column mod TAB_STOP) cells,
// with a pause for any scroll. A newline on the last row, or a character
// that wraps there, starts a scroll: a row copy through the store's read and
// write ports, then a blank last row; a clear sweeps all ROWS*COLUMNS cells,
// one a cycle. Simple commands pass through the dispatch and result-capture
// steps of the controller; the next command is taken no earlier than capture.
// Reset returns the cursor to 0,0 and the attribute to 0x07; the store keeps
// no reset, so cells are undefined until the first clear.
// A stalled receiver holds the result in the output register; a new command
// may still be accepted, but its result waits until that register is free.
module text_console_writer_top #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[2:0], char_code[10:3], color_value[14:11], cell_address[25:15], zero
    input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cursor_row[4:0], cursor_column[11:5], attribute[19:12], cell_data[35:20], zero
    output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
    import tcw_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .ctl     (ctl),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

`ifndef SYNTHESIS
    // Reported column never passes the row length
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[11:5]) <= COLUMNS))
        else $error("cursor column beyond row length");

    // Reported row stays inside the screen
    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[4:0]) < ROWS))
        else $error("cursor row beyond screen");

    // An accepted command is dispatched before the next one is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken during dispatch");
`endif

endmodule
